// ===== src/mi4_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, types and microcode tables for the 4x4 matrix inverter.
package mi4_pkg;

    localparam int ELEM_W        = 32;
    localparam int THR_W         = 31;
    localparam int T_W           = 65;   // 2x2 minor: difference of two 64-bit products
    localparam int COF_W         = 99;   // 3x3 cofactor: sum of three 97-bit products
    localparam int DET_W         = 134;  // determinant: sum of four 131-bit products
    localparam int DIGIT_W       = 8;    // multiplier digit handled per cycle
    localparam int NUM_DIGITS    = ELEM_W / DIGIT_W;
    localparam int DEF_FRAC_BITS = 16;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    // Selection of the wide operand of a product step.
    localparam logic [1:0] XSEL_ELEM = 2'd0;
    localparam logic [1:0] XSEL_T1   = 2'd1;
    localparam logic [1:0] XSEL_T2   = 2'd2;
    localparam logic [1:0] XSEL_T3   = 2'd3;

    localparam logic [3:0] LAST_STEP = 4'd8;

    typedef struct packed {
        logic                    start;
        logic                    clr;
        logic                    sub;
        logic signed [COF_W-1:0] x;
        logic [ELEM_W-1:0]       b;
    } t_mac_req;

    typedef struct packed {
        logic [3:0] x_k;
        logic [3:0] b_k;
        logic       sub;
        logic       clr;
        logic [1:0] x_sel;
    } t_step;

    // One cofactor is nine products: three 2x2 minors, then their weighted sum.
    function automatic t_step mi4_step(input logic [3:0] step);
        t_step s;
        s = '{x_k: 4'd0, b_k: 4'd0, sub: 1'b0, clr: 1'b0, x_sel: XSEL_ELEM};
        case (step)
            4'd0: s = '{x_k: 4'd4, b_k: 4'd8, sub: 1'b0, clr: 1'b1, x_sel: XSEL_ELEM};
            4'd1: s = '{x_k: 4'd5, b_k: 4'd7, sub: 1'b1, clr: 1'b0, x_sel: XSEL_ELEM};
            4'd2: s = '{x_k: 4'd3, b_k: 4'd8, sub: 1'b0, clr: 1'b1, x_sel: XSEL_ELEM};
            4'd3: s = '{x_k: 4'd5, b_k: 4'd6, sub: 1'b1, clr: 1'b0, x_sel: XSEL_ELEM};
            4'd4: s = '{x_k: 4'd3, b_k: 4'd7, sub: 1'b0, clr: 1'b1, x_sel: XSEL_ELEM};
            4'd5: s = '{x_k: 4'd4, b_k: 4'd6, sub: 1'b1, clr: 1'b0, x_sel: XSEL_ELEM};
            4'd6: s = '{x_k: 4'd0, b_k: 4'd0, sub: 1'b0, clr: 1'b1, x_sel: XSEL_T1};
            4'd7: s = '{x_k: 4'd0, b_k: 4'd1, sub: 1'b1, clr: 1'b0, x_sel: XSEL_T2};
            4'd8: s = '{x_k: 4'd0, b_k: 4'd2, sub: 1'b0, clr: 1'b0, x_sel: XSEL_T3};
            default: ;
        endcase
        return s;
    endfunction

    // Store address of the k-th element of the 3x3 minor that omits (row, col).
    function automatic logic [3:0] mi4_minor_idx(input logic [1:0] row,
                                                 input logic [1:0] col,
                                                 input logic [3:0] k);
        logic [1:0] rr;
        logic [1:0] cc;
        logic [1:0] r;
        logic [1:0] c;
        rr = 2'd0;
        cc = 2'd0;
        case (k)
            4'd0: begin rr = 2'd0; cc = 2'd0; end
            4'd1: begin rr = 2'd0; cc = 2'd1; end
            4'd2: begin rr = 2'd0; cc = 2'd2; end
            4'd3: begin rr = 2'd1; cc = 2'd0; end
            4'd4: begin rr = 2'd1; cc = 2'd1; end
            4'd5: begin rr = 2'd1; cc = 2'd2; end
            4'd6: begin rr = 2'd2; cc = 2'd0; end
            4'd7: begin rr = 2'd2; cc = 2'd1; end
            4'd8: begin rr = 2'd2; cc = 2'd2; end
            default: ;
        endcase
        r = (rr >= row) ? rr + 2'd1 : rr;
        c = (cc >= col) ? cc + 2'd1 : cc;
        return {r, c};
    endfunction

endpackage

// ===== src/mi4_in_if.sv =====
`timescale 1ns / 1ps
// Input element channel.
interface mi4_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] element;
    logic        final_element;

    modport source (output valid, element, final_element, input ready);
    modport sink (input valid, element, final_element, output ready);
endinterface

// ===== src/mi4_out_if.sv =====
`timescale 1ns / 1ps
// Result channel carrying inverse elements and status flags.
interface mi4_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [3:0]  position;
    logic        singular;
    logic        saturated;
    logic        last_of_run;

    modport source (output valid, value, position, singular, saturated, last_of_run,
                    input ready);
    modport sink (input valid, value, position, singular, saturated, last_of_run,
                  output ready);
endinterface

// ===== src/mi4_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel for the singular threshold.
interface mi4_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== src/matrix_inverse_4x4.sv =====
`timescale 1ns / 1ps
// 4x4 matrix inverse by adjugate in signed fixed point, on a shared multiplier and divider.
// Elements arrive one per transaction in row-major order; one a cycle is taken while loading,
// and the marked element starts the computation, during which no input is taken. All sixteen
// cofactors and the determinant are formed exactly by one multiply-accumulate unit that takes
// eight multiplier bits a cycle: each cofactor is nine products, and the determinant four more.
// Each of the sixteen inverse elements then takes one pass of a restoring divider, one quotient
// bit a cycle, and its output transaction; a pass ends early when the quotient is 2^32 or more.
// Each output waits while the result side holds ready low; a singular matrix gives one result
// only. The singular threshold may be written at any time the block is idle.
module matrix_inverse_4x4
    import mi4_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mi4_in_if.sink    i_in,
    mi4_cfg_if.sink   i_cfg,
    mi4_out_if.source o_out
);

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_COF_RDA  = 4'd1;
    localparam logic [3:0] S_COF_RDB  = 4'd2;
    localparam logic [3:0] S_COF_ISS  = 4'd3;
    localparam logic [3:0] S_COF_WAIT = 4'd4;
    localparam logic [3:0] S_COF_SAVE = 4'd5;
    localparam logic [3:0] S_DET_RD   = 4'd6;
    localparam logic [3:0] S_DET_ISS  = 4'd7;
    localparam logic [3:0] S_DET_WAIT = 4'd8;
    localparam logic [3:0] S_CHECK    = 4'd9;
    localparam logic [3:0] S_THR      = 4'd10;
    localparam logic [3:0] S_DIV_RD   = 4'd11;
    localparam logic [3:0] S_DIV_ISS  = 4'd12;
    localparam logic [3:0] S_DIV_WAIT = 4'd13;
    localparam logic [3:0] S_OUT      = 4'd14;

    logic [3:0]              r_state;
    logic [4:0]              r_load_cnt;
    logic [3:0]              r_cof;
    logic [3:0]              r_step;
    logic [3:0]              r_pos;
    logic [THR_W-1:0]        r_thr;

    logic [ELEM_W-1:0]       r_mat [16];
    logic [ELEM_W-1:0]       r_mat_rd;
    logic [ELEM_W-1:0]       r_xe;
    logic signed [COF_W-1:0] r_cof_mem [16];
    logic signed [COF_W-1:0] r_cof_rd;

    logic signed [T_W-1:0]   r_t1;
    logic signed [T_W-1:0]   r_t2;
    logic signed [T_W-1:0]   r_t3;
    logic [DET_W-1:0]        r_dmag;
    logic                    r_dneg;

    logic                    r_out_valid;
    logic [ELEM_W-1:0]       r_out_value;
    logic [3:0]              r_out_pos;
    logic                    r_out_sing;
    logic                    r_out_sat;
    logic                    r_out_last;

    t_mac_req                mac_req;
    logic                    mac_done;
    logic signed [DET_W-1:0] mac_acc;
    logic                    div_done;
    logic [ELEM_W-1:0]       div_value;
    logic                    div_sat;

    t_step                   step;
    logic                    cof_odd;
    logic [3:0]              mat_addr;
    logic [3:0]              cof_addr;
    logic                    in_acc;
    logic [DET_W-1:0]        limit;

    assign step    = mi4_step(r_step);
    // Cofactors at odd (row + column) carry a negative sign.
    assign cof_odd = r_cof[2] ^ r_cof[0];
    assign in_acc  = i_in.valid && i_in.ready;
    assign limit   = DET_W'(r_thr) << (3 * FRAC_BITS);

    always_comb begin
        mat_addr = r_cof;
        if (r_state == S_COF_RDA) begin
            mat_addr = mi4_minor_idx(r_cof[3:2], r_cof[1:0], step.x_k);
        end else if (r_state == S_COF_RDB) begin
            mat_addr = mi4_minor_idx(r_cof[3:2], r_cof[1:0], step.b_k);
        end
        // The inverse is the transposed adjugate.
        cof_addr = (r_state == S_DIV_RD) ? {r_pos[1:0], r_pos[3:2]} : r_cof;
    end

    always_comb begin
        mac_req.start = (r_state == S_COF_ISS) || (r_state == S_DET_ISS);
        mac_req.clr   = 1'b0;
        mac_req.sub   = 1'b0;
        mac_req.b     = r_mat_rd;
        mac_req.x     = r_cof_rd;
        if (r_state == S_COF_ISS) begin
            mac_req.clr = step.clr;
            mac_req.sub = step.sub;
            case (step.x_sel)
                XSEL_T1: begin
                    mac_req.x   = COF_W'(r_t1);
                    mac_req.sub = step.sub ^ cof_odd;
                end
                XSEL_T2: begin
                    mac_req.x   = COF_W'(r_t2);
                    mac_req.sub = step.sub ^ cof_odd;
                end
                XSEL_T3: begin
                    mac_req.x   = COF_W'(r_t3);
                    mac_req.sub = step.sub ^ cof_odd;
                end
                default: mac_req.x = COF_W'($signed(r_xe));
            endcase
        end else begin
            mac_req.clr = (r_cof == 4'd0);
        end
    end

    mi4_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    mi4_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV_ISS),
        .i_cof   (r_cof_rd),
        .i_dmag  (r_dmag),
        .i_dneg  (r_dneg),
        .o_done  (div_done),
        .o_value (div_value),
        .o_sat   (div_sat)
    );

    // Element store and cofactor store, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && in_acc && !r_load_cnt[4]) begin
            r_mat[r_load_cnt[3:0]] <= i_in.element;
        end
        r_mat_rd <= r_mat[mat_addr];
        if (r_state == S_COF_SAVE && r_step == LAST_STEP) begin
            r_cof_mem[r_cof] <= mac_acc[COF_W-1:0];
        end
        r_cof_rd <= r_cof_mem[cof_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_COF_RDB) begin
            r_xe <= r_mat_rd;
        end
        if (r_state == S_COF_SAVE) begin
            case (r_step)
                4'd1:    r_t1 <= mac_acc[T_W-1:0];
                4'd3:    r_t2 <= mac_acc[T_W-1:0];
                4'd5:    r_t3 <= mac_acc[T_W-1:0];
                default: ;
            endcase
        end
        if (r_state == S_CHECK) begin
            r_dneg <= mac_acc[DET_W-1];
            r_dmag <= mac_acc[DET_W-1] ? DET_W'(-mac_acc) : DET_W'(mac_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_load_cnt  <= 5'd0;
            r_cof       <= 4'd0;
            r_step      <= 4'd0;
            r_pos       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (i_in.final_element) begin
                            r_load_cnt <= 5'd0;
                            r_cof      <= 4'd0;
                            r_step     <= 4'd0;
                            r_state    <= S_COF_RDA;
                        end else if (!r_load_cnt[4]) begin
                            r_load_cnt <= r_load_cnt + 5'd1;
                        end
                    end
                end
                S_COF_RDA:  r_state <= S_COF_RDB;
                S_COF_RDB:  r_state <= S_COF_ISS;
                S_COF_ISS:  r_state <= S_COF_WAIT;
                S_COF_WAIT: begin
                    if (mac_done) begin
                        r_state <= S_COF_SAVE;
                    end
                end
                S_COF_SAVE: begin
                    if (r_step == LAST_STEP) begin
                        r_step <= 4'd0;
                        r_cof  <= r_cof + 4'd1;
                        if (r_cof == 4'd15) begin
                            r_state <= S_DET_RD;
                        end else begin
                            r_state <= S_COF_RDA;
                        end
                    end else begin
                        r_step  <= r_step + 4'd1;
                        r_state <= S_COF_RDA;
                    end
                end
                // Determinant: first-row elements times their cofactors.
                S_DET_RD:   r_state <= S_DET_ISS;
                S_DET_ISS:  r_state <= S_DET_WAIT;
                S_DET_WAIT: begin
                    if (mac_done) begin
                        if (r_cof == 4'd3) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_cof   <= r_cof + 4'd1;
                            r_state <= S_DET_RD;
                        end
                    end
                end
                S_CHECK:    r_state <= S_THR;
                S_THR: begin
                    r_pos <= 4'd0;
                    if (r_dmag == '0 || r_dmag < limit) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= '0;
                        r_out_pos   <= 4'd0;
                        r_out_sing  <= 1'b1;
                        r_out_sat   <= 1'b0;
                        r_out_last  <= 1'b1;
                        r_pos       <= 4'd15;
                        r_state     <= S_OUT;
                    end else begin
                        r_state <= S_DIV_RD;
                    end
                end
                S_DIV_RD:   r_state <= S_DIV_ISS;
                S_DIV_ISS:  r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= div_value;
                        r_out_pos   <= r_pos;
                        r_out_sing  <= 1'b0;
                        r_out_sat   <= div_sat;
                        r_out_last  <= (r_pos == 4'd15);
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_pos == 4'd15) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_pos   <= r_pos + 4'd1;
                            r_state <= S_DIV_RD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_LOAD);
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_out_valid;
    assign o_out.value       = r_out_value;
    assign o_out.position    = r_out_pos;
    assign o_out.singular    = r_out_sing;
    assign o_out.saturated   = r_out_sat;
    assign o_out.last_of_run = r_out_last;

endmodule

// ===== src/mi4_mac.sv =====
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: wide signed operand times 32-bit signed, 8 bits per cycle.
module mi4_mac
    import mi4_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_req                i_req,
    output logic                    o_done,
    output logic signed [DET_W-1:0] o_acc
);

    localparam int PP_W = COF_W + DIGIT_W + 1;

    logic                    r_busy;
    logic [1:0]              r_k;
    logic                    r_sub;
    logic signed [COF_W-1:0] r_x;
    logic [ELEM_W-1:0]       r_b;
    logic signed [DET_W-1:0] r_acc;

    logic signed [DIGIT_W:0] digit;
    logic signed [PP_W-1:0]  pp;
    logic signed [DET_W-1:0] ppx;

    // The top digit carries the sign of the 32-bit operand.
    always_comb begin
        case (r_k)
            2'd0:    digit = {1'b0, r_b[7:0]};
            2'd1:    digit = {1'b0, r_b[15:8]};
            2'd2:    digit = {1'b0, r_b[23:16]};
            default: digit = {r_b[31], r_b[31:24]};
        endcase
        pp  = r_x * digit;
        ppx = DET_W'(pp) <<< {r_k, 3'b000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 2'd0;
        end else if (r_busy) begin
            r_k <= r_k + 2'd1;
            if (r_k == 2'(NUM_DIGITS - 1)) begin
                r_busy <= 1'b0;
            end
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_k    <= 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_acc <= r_sub ? r_acc - ppx : r_acc + ppx;
        end else if (i_req.start) begin
            r_x   <= i_req.x;
            r_b   <= i_req.b;
            r_sub <= i_req.sub;
            if (i_req.clr) begin
                r_acc <= '0;
            end
        end
    end

    assign o_done = r_busy && (r_k == 2'(NUM_DIGITS - 1));
    assign o_acc  = r_acc;

endmodule

// ===== src/mi4_div.sv =====
`timescale 1ns / 1ps
// Shared restoring divider: one quotient bit per cycle, saturated 32-bit signed result.
module mi4_div
    import mi4_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [COF_W-1:0] i_cof,
    input  logic [DET_W-1:0]        i_dmag,
    input  logic                    i_dneg,
    output logic                    o_done,
    output logic [ELEM_W-1:0]       o_value,
    output logic                    o_sat
);

    localparam int N_W   = COF_W + 2 * FRAC_BITS;
    localparam int DS_W  = DET_W + ELEM_W;
    localparam int CMP_W = (N_W > DS_W) ? N_W : DS_W;

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;

    logic [1:0]        r_state;
    logic [5:0]        r_k;
    logic [CMP_W-1:0]  r_rem;
    logic [CMP_W-1:0]  r_ds;
    logic [ELEM_W-1:0] r_q;
    logic              r_neg;
    logic              r_sat;

    logic [COF_W-1:0]  mag;
    logic              ge;

    assign mag = i_cof[COF_W-1] ? COF_W'(-i_cof) : COF_W'(i_cof);
    assign ge  = (r_rem >= r_ds);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    // A quotient of 2^32 or more is caught on the first step.
                    if ((r_k == 6'd32 && ge) || r_k == 6'd0) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: r_state <= D_IDLE;
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_rem <= CMP_W'(mag) << (2 * FRAC_BITS);
            r_ds  <= CMP_W'(i_dmag) << ELEM_W;
            r_neg <= i_cof[COF_W-1] ^ i_dneg;
            r_sat <= 1'b0;
            r_q   <= '0;
            r_k   <= 6'd32;
        end else if (r_state == D_RUN) begin
            if (r_k == 6'd32) begin
                r_sat <= ge;
            end else begin
                r_q <= {r_q[ELEM_W-2:0], ge};
                if (ge) begin
                    r_rem <= r_rem - r_ds;
                end
            end
            r_ds <= r_ds >> 1;
            r_k  <= r_k - 6'd1;
        end
    end

    always_comb begin
        o_sat   = 1'b0;
        o_value = r_q;
        if (r_neg) begin
            if (r_sat || r_q > 32'h8000_0000) begin
                o_sat   = 1'b1;
                o_value = 32'h8000_0000;
            end else begin
                o_value = -r_q;
            end
        end else if (r_sat || r_q[ELEM_W-1]) begin
            o_sat   = 1'b1;
            o_value = 32'h7FFF_FFFF;
        end
    end

    assign o_done = (r_state == D_FIN);

endmodule

// ===== dv/mi4_checker.sv =====
`timescale 1ns / 1ps
// Checker for the 4x4 matrix inverter: watches all channels, predicts each inverse and compares.
module mi4_checker
    import mi4_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mi4_in_if    in_ch,
    mi4_cfg_if   cfg_ch,
    mi4_out_if   out_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results,
    output int   o_singulars,
    output int   o_saturations
);

    typedef logic signed [255:0] t_wide;

    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  position;
        logic        singular;
        logic        saturated;
        logic        last_of_run;
    } t_inv_result;

    logic [ELEM_W-1:0] elem_store [16];
    int                load_count;
    logic [THR_W-1:0]  threshold;
    t_inv_result       inverse_q [$];

    function automatic t_wide widen(input logic [31:0] e);
        return $signed({{224{e[31]}}, e});
    endfunction

    // Signed 3x3 minor of the element at (row, col), exact.
    function automatic t_wide cofactor_of(input int row, input int col);
        t_wide v [9];
        t_wide acc;
        int    k;
        k = 0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (r != row && c != col) begin
                    v[k] = widen(elem_store[r * 4 + c]);
                    k++;
                end
            end
        end
        acc = v[0] * (v[4] * v[8] - v[5] * v[7])
            - v[1] * (v[3] * v[8] - v[5] * v[6])
            + v[2] * (v[3] * v[7] - v[4] * v[6]);
        if ((row + col) % 2 == 1) acc = -acc;
        return acc;
    endfunction

    task automatic predict_inverse();
        t_wide        cof [16];
        t_wide        det;
        logic [255:0] dmag;
        logic [255:0] nmag;
        logic [255:0] lim;
        logic [255:0] quot;
        t_inv_result  res;
        t_wide        c;
        logic         neg;
        det = '0;
        for (int j = 0; j < 16; j++) cof[j] = cofactor_of(j / 4, j % 4);
        for (int j = 0; j < 4; j++) det = det + widen(elem_store[j]) * cof[j];
        dmag = det[255] ? -det : det;
        lim  = 256'(threshold) << (3 * DEF_FRAC_BITS);
        if (dmag == 0 || dmag < lim) begin
            res = '{value: 32'd0, position: 4'd0, singular: 1'b1, saturated: 1'b0,
                    last_of_run: 1'b1};
            inverse_q.push_back(res);
            return;
        end
        for (int p = 0; p < 16; p++) begin
            c    = cof[(p % 4) * 4 + p / 4];
            neg  = c[255] != det[255];
            nmag = c[255] ? -c : c;
            nmag = nmag << (2 * DEF_FRAC_BITS);
            quot = nmag / dmag;
            res  = '{value: 32'd0, position: 4'(p), singular: 1'b0, saturated: 1'b0,
                     last_of_run: (p == 15)};
            if (neg) begin
                if (quot > 256'h8000_0000) begin
                    res.value = 32'h8000_0000;
                    res.saturated = 1'b1;
                end else begin
                    res.value = -quot[31:0];
                end
            end else begin
                if (quot > 256'h7FFF_FFFF) begin
                    res.value = 32'h7FFF_FFFF;
                    res.saturated = 1'b1;
                end else begin
                    res.value = quot[31:0];
                end
            end
            inverse_q.push_back(res);
        end
    endtask

    task automatic inverse_q_check();
        t_inv_result got;
        t_inv_result want;
        got = '{value: out_ch.value, position: out_ch.position, singular: out_ch.singular,
                saturated: out_ch.saturated, last_of_run: out_ch.last_of_run};
        o_results++;
        if (got.singular) o_singulars++;
        if (got.saturated) o_saturations++;
        if (inverse_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: unexpected result value=%h pos=%0d", $realtime, got.value,
                         got.position);
            return;
        end
        want = inverse_q.pop_front();
        if (got !== want) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display({"%0t: mismatch exp val=%h pos=%0d sing=%b sat=%b last=%b, ",
                          "got val=%h pos=%0d sing=%b sat=%b last=%b"},
                         $realtime, want.value, want.position, want.singular,
                         want.saturated, want.last_of_run, got.value, got.position,
                         got.singular, got.saturated, got.last_of_run);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            load_count = 0;
            threshold  = THR_RESET;
            inverse_q.delete();
            for (int i = 0; i < 16; i++) elem_store[i] = '0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) threshold = cfg_ch.data;
            if (in_ch.valid && in_ch.ready) begin
                if (load_count < 16) begin
                    elem_store[load_count] = in_ch.element;
                    load_count++;
                end
                if (in_ch.final_element) begin
                    load_count = 0;
                    predict_inverse();
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                inverse_q_check();
            end
        end
        o_pending = inverse_q.size();
    end

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_results     = 0;
        o_singulars   = 0;
        o_saturations = 0;
    end

endmodule

// ===== dv/matrix_inverse_4x4_tb.sv =====
`timescale 1ns / 1ps
// Top of the 4x4 matrix inverter testbench: clock, reset, stimulus and verdict.
module matrix_inverse_4x4_tb
    import mi4_pkg::*;
();

    typedef enum int {
        MK_WELL, MK_SMALL, MK_WIDE, MK_DUP_ROW, MK_TINY_DIAG, MK_SHORT, MK_LONG
    } t_matrix_kind;

    logic i_clk;
    logic i_rst_n;

    mi4_in_if  in_ch ();
    mi4_cfg_if cfg_ch ();
    mi4_out_if out_ch ();

    int fail_count;
    int pending;
    int results;
    int singulars;
    int saturations;

    logic [31:0] mat [20];
    int          n_el;
    int          items_sent;
    int          matrices_sent;
    bit          quiet;
    bit          hold_go;
    bit          hold_done;

    matrix_inverse_4x4 dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    mi4_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .cfg_ch       (cfg_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_singulars  (singulars),
        .o_saturations(saturations)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("matrix_inverse_4x4_tb: FAIL");
        $finish;
    end

    function automatic logic [31:0] small_val(input int mag);
        return 32'($signed($urandom_range(0, 2 * mag)) - mag);
    endfunction

    task automatic build_matrix(input t_matrix_kind kind);
        int a;
        int b;
        n_el = 16;
        case (kind)
            MK_WELL: begin
                for (int i = 0; i < 16; i++) mat[i] = small_val(32'h8000);
                for (int i = 0; i < 4; i++) begin
                    a = $urandom_range(1, 4) << 16;
                    if ($urandom_range(0, 1)) a = -a;
                    mat[i * 5] = mat[i * 5] + 32'(a);
                end
            end
            MK_SMALL: for (int i = 0; i < 16; i++) mat[i] = small_val(32'h20000);
            MK_WIDE:  for (int i = 0; i < 16; i++) mat[i] = $urandom();
            MK_DUP_ROW: begin
                for (int i = 0; i < 16; i++) mat[i] = small_val(32'h40000);
                a = $urandom_range(0, 3);
                b = (a + $urandom_range(1, 3)) % 4;
                for (int c = 0; c < 4; c++) mat[b * 4 + c] = mat[a * 4 + c];
            end
            MK_TINY_DIAG: begin
                for (int i = 0; i < 16; i++) mat[i] = '0;
                for (int i = 0; i < 4; i++) begin
                    a = $urandom_range(1, 300);
                    if ($urandom_range(0, 1)) a = -a;
                    mat[i * 5] = 32'(a);
                end
                // One random term, usually off the diagonal, keeps some inverse entries in range.
                mat[$urandom_range(0, 15)] = small_val(32'h10000);
            end
            MK_SHORT: begin
                n_el = $urandom_range(1, 15);
                for (int i = 0; i < n_el; i++) mat[i] = small_val(32'h30000);
            end
            default: begin
                n_el = $urandom_range(17, 20);
                for (int i = 0; i < n_el; i++) mat[i] = small_val(32'h30000);
            end
        endcase
    endtask

    // Offers each element and waits for its transaction; the mark goes on the last one.
    task automatic send_matrix();
        for (int i = 0; i < n_el; i++) begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            in_ch.valid         <= 1'b1;
            in_ch.element       <= mat[i];
            in_ch.final_element <= (i == n_el - 1);
            @(posedge i_clk);
            while (!in_ch.ready) @(posedge i_clk);
            items_sent++;
        end
        matrices_sent++;
    endtask

    task automatic drain();
        int guard;
        in_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        guard = 0;
        while (pending != 0) begin
            @(posedge i_clk);
            guard++;
            if (guard > 200000) begin
                $display("matrix_inverse_4x4_tb: FAIL");
                $finish;
            end
        end
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] thr);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= thr;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int n_items);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      build_matrix(MK_WELL);
            else if (pick < 55) build_matrix(MK_SMALL);
            else if (pick < 65) build_matrix(MK_WIDE);
            else if (pick < 75) build_matrix(MK_DUP_ROW);
            else if (pick < 83) build_matrix(MK_TINY_DIAG);
            else if (pick < 92) build_matrix(MK_SHORT);
            else                build_matrix(MK_LONG);
            send_matrix();
        end
    endtask

    // Result side: random stalls, and one long hold-off on request.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        in_ch.valid         <= 1'b0;
        in_ch.element       <= '0;
        in_ch.final_element <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= '0;
        i_rst_n             <= 1'b0;
        items_sent    = 0;
        matrices_sent = 0;
        quiet         = 1'b0;
        hold_go       = 1'b0;
        hold_done     = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, then a short matrix carrying the element extremes.
        for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? 32'h0001_0000 : 32'h0;
        n_el = 16;
        send_matrix();
        mat[0] = 32'h7FFF_FFFF;
        mat[1] = 32'h8000_0000;
        mat[2] = 32'h0;
        mat[3] = 32'hFFFF_FFFF;
        n_el = 4;
        send_matrix();
        drain();

        write_threshold(THR_W'(0));
        build_matrix(MK_DUP_ROW);
        send_matrix();
        // Long hold-off on the result side while elements keep being offered.
        hold_go = 1'b1;
        random_phase(50);
        drain();
        random_phase(30);
        drain();

        write_threshold(THR_W'(32'h0001_0000));
        random_phase(50);
        drain();

        write_threshold({THR_W{1'b1}});
        build_matrix(MK_WIDE);
        send_matrix();
        random_phase(30);
        drain();

        write_threshold(THR_W'($urandom_range(0, 32'h0000_4000)));
        random_phase(60);
        drain();

        write_threshold(THR_W'(1));
        random_phase(60);
        quiet = 1'b1;
        random_phase(70);
        drain();

        $display("Sent %0d elements in %0d matrices; checked %0d results", items_sent,
                 matrices_sent, results);
        $display("of which %0d singular and %0d saturated, with %0d mismatches",
                 singulars, saturations, fail_count);
        if (fail_count == 0) begin
            $display("matrix_inverse_4x4_tb: PASS");
        end else begin
            $display("matrix_inverse_4x4_tb: FAIL");
        end
        $finish;
    end
endmodule
